// ===== hw/rtl/esmne_pkg.sv =====
// Shared types, widths and codes of the normal-equation accumulator.
package esmne_pkg;

	localparam int COORD_W  = 6;
	localparam int DIM_W    = 7;
	localparam int SAMPLE_W = 13;
	localparam int GRAD_W   = 14;
	localparam int J_W      = 15;
	localparam int D_W      = 7;
	localparam int E_W      = 15;
	localparam int PD_W     = D_W + J_W;
	localparam int J2_W     = PD_W + 1;
	localparam int SUM_W    = 64;
	localparam int NUM_SUMS = 15;
	localparam int IDX_W    = 4;
	localparam int CFG_IDX_W = 2;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W   = QPTR_W + 1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MEAN_OFFSET  = 2'd2;

	localparam logic [DIM_W-1:0] WIDTH_RESET  = 7'd40;
	localparam logic [DIM_W-1:0] HEIGHT_RESET = 7'd30;

	// Sum indexes on the output.
	localparam logic [IDX_W-1:0] SUM_J0J0  = 4'd0;
	localparam logic [IDX_W-1:0] SUM_J1J0  = 4'd1;
	localparam logic [IDX_W-1:0] SUM_J1J1  = 4'd2;
	localparam logic [IDX_W-1:0] SUM_J2J0  = 4'd3;
	localparam logic [IDX_W-1:0] SUM_J2J1  = 4'd4;
	localparam logic [IDX_W-1:0] SUM_J2J2  = 4'd5;
	localparam logic [IDX_W-1:0] SUM_J0    = 4'd6;
	localparam logic [IDX_W-1:0] SUM_J1    = 4'd7;
	localparam logic [IDX_W-1:0] SUM_J2    = 4'd8;
	localparam logic [IDX_W-1:0] SUM_COUNT = 4'd9;
	localparam logic [IDX_W-1:0] SUM_EJ0   = 4'd10;
	localparam logic [IDX_W-1:0] SUM_EJ1   = 4'd11;
	localparam logic [IDX_W-1:0] SUM_EJ2   = 4'd12;
	localparam logic [IDX_W-1:0] SUM_E     = 4'd13;
	localparam logic [IDX_W-1:0] SUM_EE    = 4'd14;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [GRAD_W-1:0]   grad_t;
	typedef logic [COORD_W-1:0]         coord_t;
	typedef logic [DIM_W-1:0]           dim_t;
	typedef logic signed [SUM_W-1:0]    sum_t;
	typedef logic [IDX_W-1:0]           sum_idx_t;

	// One classified pixel as it travels from the front to the back.
	typedef struct packed {
		logic                  use_px;
		logic                  last;
		logic signed [J_W-1:0] j0;
		logic signed [J_W-1:0] j1;
		logic signed [E_W-1:0] e;
		logic signed [D_W-1:0] dx;
		logic signed [D_W-1:0] dy;
	} item_t;

endpackage

// ===== hw/rtl/esmne_front.sv =====
// Front end: configuration registers, pixel classification and Jacobian terms.
module esmne_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic [esmne_pkg::CFG_IDX_W-1:0] cfg_index,
	input  esmne_pkg::sample_t            cfg_data,
	input  logic                          in_fire,
	input  esmne_pkg::coord_t             pixel_x,
	input  esmne_pkg::coord_t             pixel_y,
	input  esmne_pkg::sample_t            warped_centre,
	input  esmne_pkg::sample_t            warped_left,
	input  esmne_pkg::sample_t            warped_right,
	input  esmne_pkg::sample_t            warped_up,
	input  esmne_pkg::sample_t            warped_down,
	input  logic                          neighbours_valid,
	input  esmne_pkg::sample_t            target_value,
	input  esmne_pkg::grad_t              target_grad_x,
	input  esmne_pkg::grad_t              target_grad_y,
	input  logic                          frame_end,
	output logic                          push,
	output esmne_pkg::item_t              push_item
);
	import esmne_pkg::*;

	dim_t    width_q;
	dim_t    height_q;
	sample_t offset_q;

	logic               in_x;
	logic               in_y;
	logic [COORD_W-1:0] cx;
	logic [COORD_W-1:0] cy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			offset_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH:  width_q  <= cfg_data[DIM_W-1:0];
				CFG_IMAGE_HEIGHT: height_q <= cfg_data[DIM_W-1:0];
				CFG_MEAN_OFFSET:  offset_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// A pixel counts only strictly inside the one-pixel border.
	assign in_x = (pixel_x != '0) &&
		(({2'b00, pixel_x} + 8'd2) <= {1'b0, width_q});
	assign in_y = (pixel_y != '0) &&
		(({2'b00, pixel_y} + 8'd2) <= {1'b0, height_q});
	assign cx = width_q[DIM_W-1:1];
	assign cy = height_q[DIM_W-1:1];

	always_comb begin
		push_item.use_px = neighbours_valid && in_x && in_y;
		push_item.last   = frame_end;
		push_item.j0     = J_W'(warped_right) - J_W'(warped_left) + J_W'(target_grad_x);
		push_item.j1     = J_W'(warped_down) - J_W'(warped_up) + J_W'(target_grad_y);
		push_item.e      = E_W'(warped_centre) - E_W'(target_value) + E_W'(offset_q);
		push_item.dx     = signed'({1'b0, pixel_x}) - signed'({1'b0, cx});
		push_item.dy     = signed'({1'b0, pixel_y}) - signed'({1'b0, cy});
	end

	// Skipped pixels are dropped here unless they close the frame.
	assign push = in_fire && (push_item.use_px || frame_end);

endmodule

// ===== hw/rtl/esmne_fifo.sv =====
// Short queue of classified pixels between the front and back ends.
module esmne_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  esmne_pkg::item_t push_item,
	output logic             full,
	output logic             pop_valid,
	input  logic             pop_ready,
	output esmne_pkg::item_t pop_item
);
	import esmne_pkg::*;

	item_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_q;
	logic [QPTR_W-1:0]  rd_q;
	logic [QCNT_W-1:0]  cnt_q;
	logic               pop;

	assign full      = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign pop_valid = (cnt_q != '0);
	assign pop       = pop_valid && pop_ready;
	assign pop_item  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/esmne_back.sv =====
// Back end: product pipeline, the fifteen accumulators and the sum readout.
module esmne_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pop_valid,
	output logic                 pop_ready,
	input  esmne_pkg::item_t     pop_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output esmne_pkg::sum_idx_t  sum_index,
	output esmne_pkg::sum_t      sum_value,
	output logic                 last_sum
);
	import esmne_pkg::*;

	logic pop;
	logic hold_q;
	logic drain_q;
	logic [IDX_W-1:0] cnt_q;
	logic load;

	// Stage 1: rotation partial products.
	logic                   v_s1, use_s1, last_s1;
	logic signed [J_W-1:0]  j0_s1, j1_s1;
	logic signed [E_W-1:0]  e_s1;
	logic signed [PD_W-1:0] dyj0_s1, dxj1_s1;
	// Stage 2: rotation term.
	logic                   v_s2, use_s2, last_s2;
	logic signed [J_W-1:0]  j0_s2, j1_s2;
	logic signed [E_W-1:0]  e_s2;
	logic signed [J2_W-1:0] j2_s2;
	// Stage 3: all products.
	logic                       v_s3, use_s3, last_s3;
	logic signed [J_W-1:0]      j0_s3, j1_s3;
	logic signed [J2_W-1:0]     j2_s3;
	logic signed [E_W-1:0]      e_s3;
	logic signed [2*J_W-1:0]    p00_s3, p10_s3, p11_s3;
	logic signed [J2_W+J_W-1:0] p20_s3, p21_s3;
	logic signed [2*J2_W-1:0]   p22_s3;
	logic signed [E_W+J_W-1:0]  pe0_s3, pe1_s3;
	logic signed [E_W+J2_W-1:0] pe2_s3;
	logic signed [2*E_W-1:0]    pee_s3;

	sum_t acc_q [NUM_SUMS];
	sum_t term  [NUM_SUMS];

	assign pop_ready = !hold_q;
	assign pop       = pop_valid && pop_ready;
	assign load      = drain_q && (!out_valid || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		use_s1  <= pop_item.use_px;
		last_s1 <= pop_item.last;
		j0_s1   <= pop_item.j0;
		j1_s1   <= pop_item.j1;
		e_s1    <= pop_item.e;
		dyj0_s1 <= pop_item.dy * pop_item.j0;
		dxj1_s1 <= pop_item.dx * pop_item.j1;

		use_s2  <= use_s1;
		last_s2 <= last_s1;
		j0_s2   <= j0_s1;
		j1_s2   <= j1_s1;
		e_s2    <= e_s1;
		j2_s2   <= J2_W'(dxj1_s1) - J2_W'(dyj0_s1);

		use_s3  <= use_s2;
		last_s3 <= last_s2;
		j0_s3   <= j0_s2;
		j1_s3   <= j1_s2;
		j2_s3   <= j2_s2;
		e_s3    <= e_s2;
		p00_s3  <= j0_s2 * j0_s2;
		p10_s3  <= j1_s2 * j0_s2;
		p11_s3  <= j1_s2 * j1_s2;
		p20_s3  <= j2_s2 * j0_s2;
		p21_s3  <= j2_s2 * j1_s2;
		p22_s3  <= j2_s2 * j2_s2;
		pe0_s3  <= e_s2 * j0_s2;
		pe1_s3  <= e_s2 * j1_s2;
		pe2_s3  <= e_s2 * j2_s2;
		pee_s3  <= e_s2 * e_s2;
	end

	always_comb begin
		term[SUM_J0J0]  = SUM_W'(p00_s3);
		term[SUM_J1J0]  = SUM_W'(p10_s3);
		term[SUM_J1J1]  = SUM_W'(p11_s3);
		term[SUM_J2J0]  = SUM_W'(p20_s3);
		term[SUM_J2J1]  = SUM_W'(p21_s3);
		term[SUM_J2J2]  = SUM_W'(p22_s3);
		term[SUM_J0]    = SUM_W'(j0_s3);
		term[SUM_J1]    = SUM_W'(j1_s3);
		term[SUM_J2]    = SUM_W'(j2_s3);
		term[SUM_COUNT] = SUM_W'(1);
		term[SUM_EJ0]   = SUM_W'(pe0_s3);
		term[SUM_EJ1]   = SUM_W'(pe1_s3);
		term[SUM_EJ2]   = SUM_W'(pe2_s3);
		term[SUM_E]     = SUM_W'(e_s3);
		term[SUM_EE]    = SUM_W'(pee_s3);
	end

	// Accumulators; cleared as the score sum is handed to the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_SUMS; k++) begin
				acc_q[k] <= '0;
			end
		end else if (load && (cnt_q == SUM_EE)) begin
			for (int k = 0; k < NUM_SUMS; k++) begin
				acc_q[k] <= '0;
			end
		end else if (v_s3 && use_s3) begin
			for (int k = 0; k < NUM_SUMS; k++) begin
				acc_q[k] <= acc_q[k] + term[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q    <= 1'b0;
			drain_q   <= 1'b0;
			cnt_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (pop && pop_item.last) begin
				hold_q <= 1'b1;
			end
			if (v_s3 && last_s3) begin
				drain_q <= 1'b1;
				cnt_q   <= '0;
			end
			if (load) begin
				out_valid <= 1'b1;
				cnt_q     <= cnt_q + 1'b1;
				if (cnt_q == SUM_EE) begin
					drain_q <= 1'b0;
					hold_q  <= 1'b0;
				end
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sum_index <= cnt_q;
			sum_value <= acc_q[cnt_q];
			last_sum  <= (cnt_q == SUM_EE);
		end
	end

endmodule

// ===== hw/rtl/esm_normal_equation_accumulator_top.sv =====
// Top level of the normal-equation accumulator.
// Throughput: one pixel word per cycle while the queue has room. A pixel marked
// frame_end stops the queue feeding the back end through the pipeline flush and
// the readout of the fifteen sums, and longer if the output side stalls.
// A pixel's products pass the rotation partial-product, rotation-term and product
// registers into the accumulators; at frame end the sums leave by the output register.
// Reset (arst_n low) empties the queue, clears every sum and loads 40 by 30, offset zero.
module esm_normal_equation_accumulator_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [esmne_pkg::CFG_IDX_W-1:0] cfg_index,
	input  esmne_pkg::sample_t              cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  esmne_pkg::coord_t               pixel_x,
	input  esmne_pkg::coord_t               pixel_y,
	input  esmne_pkg::sample_t              warped_centre,
	input  esmne_pkg::sample_t              warped_left,
	input  esmne_pkg::sample_t              warped_right,
	input  esmne_pkg::sample_t              warped_up,
	input  esmne_pkg::sample_t              warped_down,
	input  logic                            neighbours_valid,
	input  esmne_pkg::sample_t              target_value,
	input  esmne_pkg::grad_t                target_grad_x,
	input  esmne_pkg::grad_t                target_grad_y,
	input  logic                            frame_end,
	output logic                            out_valid,
	input  logic                            out_ready,
	output esmne_pkg::sum_idx_t             sum_index,
	output esmne_pkg::sum_t                 sum_value,
	output logic                            last_sum
);
	import esmne_pkg::*;

	logic  full;
	logic  in_fire;
	logic  push;
	item_t push_item;
	item_t pop_item;
	logic  pop_valid;
	logic  pop_ready;

	// Configuration writes are always taken; users must write only when idle, unchecked.
	assign cfg_ready = 1'b1;

	// The front only needs space in the queue, so the input side keeps moving
	// while the back end accumulates, and while it waits on the output until the queue fills.
	assign in_ready = !full;
	assign in_fire  = in_valid && in_ready;

	esmne_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_fire          (in_fire),
		.pixel_x          (pixel_x),
		.pixel_y          (pixel_y),
		.warped_centre    (warped_centre),
		.warped_left      (warped_left),
		.warped_right     (warped_right),
		.warped_up        (warped_up),
		.warped_down      (warped_down),
		.neighbours_valid (neighbours_valid),
		.target_value     (target_value),
		.target_grad_x    (target_grad_x),
		.target_grad_y    (target_grad_y),
		.frame_end        (frame_end),
		.push             (push),
		.push_item        (push_item)
	);

	// Four-entry queue of classified pixels.
	esmne_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item)
	);

	// The back end multiplies, accumulates and reads the sums out through a
	// registered output word that is refilled, while sums remain, in the cycle it is taken.
	esmne_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sum_index (sum_index),
		.sum_value (sum_value),
		.last_sum  (last_sum)
	);

endmodule

// ===== hw/rtl/esmne_checker.sv =====
// Port-level checker of the accumulator and its bind to the top level.
module esmne_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input esmne_pkg::sum_idx_t sum_index,
	input esmne_pkg::sum_t     sum_value,
	input logic                last_sum
);
	import esmne_pkg::*;

	sum_idx_t expect_q;

	// Index the next output word must carry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_q <= SUM_J0J0;
		end else if (out_valid && out_ready) begin
			expect_q <= (sum_index == SUM_EE) ? SUM_J0J0 : sum_index + 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sum_index) && $stable(sum_value))
		else $error("output word changed while stalled");

	a_index_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> sum_index == expect_q)
		else $error("sum words out of order");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_sum == (sum_index == SUM_EE)))
		else $error("last_sum not on the score word");

	a_squares_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (sum_index == SUM_J0J0 || sum_index == SUM_J1J1 ||
			sum_index == SUM_J2J2 || sum_index == SUM_COUNT || sum_index == SUM_EE)
		|-> !sum_value[SUM_W-1])
		else $error("sum of squares or count is negative");

endmodule

bind esm_normal_equation_accumulator_top esmne_checker u_checker (.*);
